>>> design/weighted_line_fit_accumulator_core_defines.svh
// Assertion macros shared by the line fit accumulator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef WEIGHTED_LINE_FIT_ACCUMULATOR_CORE_DEFINES_SVH
`define WEIGHTED_LINE_FIT_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wlf: assertion failed");
// next-cycle implication
`define WLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wlf: assertion failed");
`else
`define WLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define WLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> design/wlf_pkg.sv
// Types and constants of the weighted line fit accumulator.
// No dependencies; used by wlf_ctrl, wlf_dp and the top level.
package wlf_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR_ADD = 2'd0,
    OP_ADD       = 2'd1,
    OP_SOLVE     = 2'd2,
    OP_RESIDUAL  = 2'd3
  } opcode_e;

  localparam logic KIND_SOLVE    = 1'b0;
  localparam logic KIND_RESIDUAL = 1'b1;

  // which 128-bit quantity the product unit is building
  typedef enum logic [1:0] {
    QTY_DEN = 2'd0,
    QTY_NC  = 2'd1,
    QTY_NT  = 2'd2
  } qty_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIT_MUL1,
    ST_HIT_MUL2,
    ST_HIT_ACC,
    ST_RES_MUL,
    ST_RES_SUB,
    ST_SOLVE_MAG,
    ST_PROD_MUL,
    ST_PROD_DRAIN,
    ST_DEN_CHECK,
    ST_NUM_LOAD,
    ST_DIV,
    ST_DIV_DONE,
    ST_OUT
  } state_e;

  localparam int CNT_W          = 8;
  localparam int DIV_NUM_W      = 128;
  localparam int INTERCEPT_FRAC = 8;
  localparam int SLOPE_FRAC     = 24;

  localparam logic [CNT_W-1:0] DIV_STEPS_INTERCEPT = CNT_W'(DIV_NUM_W + INTERCEPT_FRAC);
  localparam logic [CNT_W-1:0] DIV_STEPS_SLOPE     = CNT_W'(DIV_NUM_W + SLOPE_FRAC);
  localparam logic [2:0]       MUL_LAST_PART       = 3'd7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] hit_coord;
    logic signed [23:0] hit_z;
    logic [15:0]        hit_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] intercept;
    logic signed [31:0] slope;
    logic signed [23:0] residual;
    logic               singular;
    logic               result_kind;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       hit_mul1;
    logic       hit_mul2;
    logic       hit_acc;
    logic       res_mul;
    logic       res_sub;
    logic       mag_latch;
    logic       mul_issue;
    logic [2:0] mul_part;   // [2] term, [1] a half, [0] b half
    qty_e       qty;
    logic       acc_clr;
    logic       den_latch;
    logic       div_load;
    logic       div_step;
    logic       div_write;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic out_free;
  } dp_sts_t;

endpackage

>>> design/wlf_ctrl.sv
// Sequencer of the line fit accumulator: one item at a time.
// Depends on wlf_pkg and the assertion macro header.
`include "weighted_line_fit_accumulator_core_defines.svh"

module wlf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_opcode_i,
  output logic             in_stall_o,
  input  wlf_pkg::dp_sts_t sts_i,
  output wlf_pkg::dp_cmd_t cmd_o
);
  import wlf_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  qty_e             qty_q, qty_d;
  logic [CNT_W-1:0] div_steps;

  assign div_steps = (qty_q == QTY_NT) ? DIV_STEPS_SLOPE : DIV_STEPS_INTERCEPT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      qty_q   <= QTY_DEN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      qty_q   <= qty_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    qty_d   = qty_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_opcode_i)
            OP_CLEAR_ADD: state_d = ST_HIT_MUL1;
            OP_ADD:       state_d = ST_HIT_MUL1;
            OP_SOLVE:     state_d = ST_SOLVE_MAG;
            OP_RESIDUAL:  state_d = ST_RES_MUL;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_HIT_MUL1: state_d = ST_HIT_MUL2;
      ST_HIT_MUL2: state_d = ST_HIT_ACC;
      ST_HIT_ACC:  state_d = ST_IDLE;
      ST_RES_MUL:  state_d = ST_RES_SUB;
      ST_RES_SUB:  state_d = ST_OUT;
      ST_SOLVE_MAG: begin
        qty_d   = QTY_DEN;
        cnt_d   = '0;
        state_d = ST_PROD_MUL;
      end
      ST_PROD_MUL: begin
        if (cnt_q[2:0] == MUL_LAST_PART) begin
          cnt_d   = '0;
          state_d = ST_PROD_DRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_PROD_DRAIN: state_d = (qty_q == QTY_DEN) ? ST_DEN_CHECK : ST_NUM_LOAD;
      ST_DEN_CHECK: begin
        if (sts_i.den_zero) begin
          state_d = ST_OUT;
        end else begin
          qty_d   = QTY_NC;
          cnt_d   = '0;
          state_d = ST_PROD_MUL;
        end
      end
      ST_NUM_LOAD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == div_steps - CNT_W'(1)) begin
          cnt_d   = '0;
          state_d = ST_DIV_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV_DONE: begin
        if (qty_q == QTY_NC) begin
          qty_d   = QTY_NT;
          cnt_d   = '0;
          state_d = ST_PROD_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_part = cnt_q[2:0];
    cmd_o.qty      = qty_q;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_HIT_MUL1:  cmd_o.hit_mul1  = 1'b1;
      ST_HIT_MUL2:  cmd_o.hit_mul2  = 1'b1;
      ST_HIT_ACC:   cmd_o.hit_acc   = 1'b1;
      ST_RES_MUL:   cmd_o.res_mul   = 1'b1;
      ST_RES_SUB:   cmd_o.res_sub   = 1'b1;
      ST_SOLVE_MAG: cmd_o.mag_latch = 1'b1;
      ST_PROD_MUL: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.acc_clr   = (cnt_q[2:0] == 3'd0);
      end
      ST_PROD_DRAIN: cmd_o.mul_issue = 1'b0;
      ST_DEN_CHECK:  cmd_o.den_latch = 1'b1;
      ST_NUM_LOAD:   cmd_o.div_load  = 1'b1;
      ST_DIV:        cmd_o.div_step  = 1'b1;
      ST_DIV_DONE:   cmd_o.div_write = 1'b1;
      ST_OUT:        cmd_o.out_load  = sts_i.out_free;
      default:       cmd_o.capture   = 1'b0;
    endcase
  end

  `WLF_ASSERT_IMPL(a_div_cnt_range, clk_i, rst_ni, (state_q == ST_DIV), (cnt_q < DIV_STEPS_SLOPE))
  `WLF_ASSERT_NEXT(a_solve_start, clk_i, rst_ni, (state_q == ST_IDLE && in_valid_i && in_opcode_i == OP_SOLVE), (state_q == ST_SOLVE_MAG))
  `WLF_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, (state_q != ST_IDLE), in_stall_o)

endmodule

>>> design/wlf_dp.sv
// Datapath of the line fit accumulator: hit products, saturating sums,
// 32x32 product unit, restoring divider, residual and result register.
// Depends on wlf_pkg and the assertion macro header.
`include "weighted_line_fit_accumulator_core_defines.svh"

module wlf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [23:0] cfg_wdata_i,
  input  wlf_pkg::in_item_t  in_item_i,
  input  wlf_pkg::dp_cmd_t   cmd_i,
  output wlf_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wlf_pkg::out_item_t out_item_o
);
  import wlf_pkg::*;

  localparam logic [32:0] SLOPE_CAP     = 33'd2147483648;
  localparam logic [32:0] INTERCEPT_CAP = 33'd8388608;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add64 = s[63:0];
  endfunction

  // configuration and captured item
  logic signed [23:0] ref_z_q;
  logic [1:0]         op_q;
  logic signed [23:0] c_q;
  logic signed [24:0] z_q;
  logic [15:0]        w_q;

  // hit products
  logic signed [41:0] wz_full;
  logic signed [40:0] wc_full;
  logic signed [48:0] cz_full;
  logic [23:0]        zabs;
  logic [47:0]        zz_full;
  logic [63:0]        wzz_full;
  logic signed [64:0] wcz_full;
  logic signed [40:0] wz_q;
  logic signed [39:0] wc_q;
  logic signed [47:0] cz_q;
  logic [47:0]        zz_q;
  logic [55:0]        wzz_q;
  logic signed [55:0] wcz_q;

  // sums and line
  logic [31:0]        sum_w_q;
  logic signed [63:0] sum_wz_q, sum_wzz_q, sum_wc_q, sum_wcz_q;
  logic [31:0]        base_w;
  logic signed [63:0] base_wz, base_wzz, base_wc, base_wcz;
  logic [32:0]        sum_w_ext;
  logic signed [23:0] intercept_q;
  logic signed [31:0] slope_q;

  // residual
  logic signed [56:0] zs_full;
  logic signed [56:0] zs_q;
  logic signed [34:0] res_diff;
  logic signed [23:0] resid_q;
  logic               sing_q;

  // product unit
  logic [63:0]  mag_sz_q, mag_sz2_q, mag_sc_q, mag_scz_q;
  logic         neg_sz_q, neg_sz2_q, neg_sc_q, neg_scz_q;
  logic [63:0]  s0_mag;
  logic [63:0]  a_mag, b_mag;
  logic         a_neg, b_neg;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp_q;
  logic [1:0]   pp_shift_q;
  logic         pp_neg_q, pp_vld_q;
  logic [128:0] addend;
  logic [128:0] acc_q;
  logic [127:0] acc_mag;

  // divider
  logic [127:0] den_mag_q;
  logic         den_neg_q;
  logic [127:0] num_q;
  logic [126:0] rem_q;
  logic [32:0]  quo_q;
  logic         qneg_q;
  logic [127:0] r2;
  logic [128:0] rdiff;
  logic         qbit;
  logic [32:0]  q2;
  logic [32:0]  cap;
  logic [31:0]  cap32, quo32, div_res;
  logic         quo_ge;

  out_item_t out_q;
  logic      out_valid_q;

  // ---------------- hit path ----------------
  assign wz_full  = $signed({1'b0, w_q}) * z_q;
  assign wc_full  = $signed({1'b0, w_q}) * c_q;
  assign cz_full  = c_q * z_q;
  assign zabs     = z_q[24] ? 24'(~z_q + 25'd1) : z_q[23:0];
  assign zz_full  = zabs * zabs;
  assign wzz_full = zz_q * w_q;
  assign wcz_full = cz_q * $signed({1'b0, w_q});

  assign base_w   = (op_q == OP_CLEAR_ADD) ? '0 : sum_w_q;
  assign base_wz  = (op_q == OP_CLEAR_ADD) ? '0 : sum_wz_q;
  assign base_wzz = (op_q == OP_CLEAR_ADD) ? '0 : sum_wzz_q;
  assign base_wc  = (op_q == OP_CLEAR_ADD) ? '0 : sum_wc_q;
  assign base_wcz = (op_q == OP_CLEAR_ADD) ? '0 : sum_wcz_q;
  assign sum_w_ext = {1'b0, base_w} + {17'd0, w_q};

  // ---------------- residual ----------------
  assign zs_full  = z_q * slope_q;
  // floor(z * slope / 2^24) is the arithmetic shift of the product
  assign res_diff = {{11{c_q[23]}}, c_q} - {{11{intercept_q[23]}}, intercept_q}
                  - {{2{zs_q[56]}}, zs_q[56:24]};

  // ---------------- product unit ----------------
  assign s0_mag = {24'd0, sum_w_q, 8'd0};

  always_comb begin
    a_mag = '0;
    b_mag = '0;
    a_neg = 1'b0;
    b_neg = 1'b0;
    case (cmd_i.qty)
      QTY_DEN: begin
        if (!cmd_i.mul_part[2]) begin
          a_mag = mag_sz_q;  a_neg = neg_sz_q;  b_mag = mag_sz_q;  b_neg = neg_sz_q;
        end else begin
          a_mag = s0_mag;    a_neg = 1'b0;      b_mag = mag_sz2_q; b_neg = neg_sz2_q;
        end
      end
      QTY_NC: begin
        if (!cmd_i.mul_part[2]) begin
          a_mag = mag_scz_q; a_neg = neg_scz_q; b_mag = mag_sz_q;  b_neg = neg_sz_q;
        end else begin
          a_mag = mag_sc_q;  a_neg = neg_sc_q;  b_mag = mag_sz2_q; b_neg = neg_sz2_q;
        end
      end
      QTY_NT: begin
        if (!cmd_i.mul_part[2]) begin
          a_mag = mag_sc_q;  a_neg = neg_sc_q;  b_mag = mag_sz_q;  b_neg = neg_sz_q;
        end else begin
          a_mag = s0_mag;    a_neg = 1'b0;      b_mag = mag_scz_q; b_neg = neg_scz_q;
        end
      end
      default: a_mag = '0;
    endcase
  end

  assign a_half  = cmd_i.mul_part[1] ? a_mag[63:32] : a_mag[31:0];
  assign b_half  = cmd_i.mul_part[0] ? b_mag[63:32] : b_mag[31:0];
  assign addend  = {65'd0, pp_q} << {pp_shift_q, 5'd0};
  assign acc_mag = acc_q[128] ? (~acc_q[127:0] + 128'd1) : acc_q[127:0];

  // ---------------- divider ----------------
  assign r2     = {rem_q, num_q[127]};
  assign rdiff  = {1'b0, r2} - {1'b0, den_mag_q};
  assign qbit   = !rdiff[128];
  assign q2     = {quo_q[31:0], qbit};
  assign cap    = (cmd_i.qty == QTY_NT) ? SLOPE_CAP : INTERCEPT_CAP;
  assign cap32  = cap[31:0];
  assign quo32  = quo_q[31:0];
  assign quo_ge = (quo_q >= cap);
  assign div_res = qneg_q ? (quo_ge ? (~cap32 + 32'd1) : (~quo32 + 32'd1))
                          : (quo_ge ? (cap32 - 32'd1) : quo32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_z_q     <= '0;
      sum_w_q     <= '0;
      sum_wz_q    <= '0;
      sum_wzz_q   <= '0;
      sum_wc_q    <= '0;
      sum_wcz_q   <= '0;
      intercept_q <= '0;
      slope_q     <= '0;
      pp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ref_z_q <= cfg_wdata_i;
      if (cmd_i.hit_acc) begin
        sum_w_q   <= sum_w_ext[32] ? '1 : sum_w_ext[31:0];
        sum_wz_q  <= sat_add64(base_wz, {{23{wz_q[40]}}, wz_q});
        sum_wzz_q <= sat_add64(base_wzz, {8'd0, wzz_q});
        sum_wc_q  <= sat_add64(base_wc, {{24{wc_q[39]}}, wc_q});
        sum_wcz_q <= sat_add64(base_wcz, {{8{wcz_q[55]}}, wcz_q});
      end
      if (cmd_i.div_write) begin
        if (cmd_i.qty == QTY_NT) slope_q <= div_res;
        else intercept_q <= div_res[23:0];
      end
      pp_vld_q <= cmd_i.mul_issue;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_item_i.opcode;
      c_q     <= in_item_i.hit_coord;
      z_q     <= {in_item_i.hit_z[23], in_item_i.hit_z} - {ref_z_q[23], ref_z_q};
      w_q     <= in_item_i.hit_weight;
      resid_q <= '0;
      sing_q  <= 1'b0;
    end
    if (cmd_i.hit_mul1) begin
      wz_q <= wz_full[40:0];
      wc_q <= wc_full[39:0];
      cz_q <= cz_full[47:0];
      zz_q <= zz_full;
    end
    if (cmd_i.hit_mul2) begin
      wzz_q <= wzz_full[63:8];
      wcz_q <= wcz_full[63:8];
    end
    if (cmd_i.res_mul) zs_q <= zs_full;
    if (cmd_i.res_sub) begin
      if (res_diff[34:23] == {12{res_diff[34]}}) resid_q <= res_diff[23:0];
      else resid_q <= res_diff[34] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    end
    if (cmd_i.mag_latch) begin
      mag_sz_q  <= abs64(sum_wz_q);   neg_sz_q  <= sum_wz_q[63];
      mag_sz2_q <= abs64(sum_wzz_q);  neg_sz2_q <= sum_wzz_q[63];
      mag_sc_q  <= abs64(sum_wc_q);   neg_sc_q  <= sum_wc_q[63];
      mag_scz_q <= abs64(sum_wcz_q);  neg_scz_q <= sum_wcz_q[63];
    end
    if (cmd_i.mul_issue) begin
      pp_q       <= a_half * b_half;
      pp_shift_q <= {1'b0, cmd_i.mul_part[1]} + {1'b0, cmd_i.mul_part[0]};
      pp_neg_q   <= a_neg ^ b_neg ^ cmd_i.mul_part[2];
    end
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (pp_vld_q) acc_q <= pp_neg_q ? (acc_q + ~addend + 129'd1) : (acc_q + addend);
    if (cmd_i.den_latch) begin
      den_mag_q <= acc_mag;
      den_neg_q <= acc_q[128];
      sing_q    <= (acc_q == '0);
    end
    if (cmd_i.div_load) begin
      num_q  <= acc_mag;
      qneg_q <= acc_q[128] ^ den_neg_q;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[126:0], 1'b0};
      rem_q <= qbit ? rdiff[126:0] : r2[126:0];
      quo_q <= (q2 > cap) ? (cap + 33'd1) : q2;
    end
    if (cmd_i.out_load) begin
      out_q.intercept   <= intercept_q;
      out_q.slope       <= slope_q;
      out_q.residual    <= resid_q;
      out_q.singular    <= sing_q;
      out_q.result_kind <= (op_q == OP_RESIDUAL) ? KIND_RESIDUAL : KIND_SOLVE;
    end
  end

  assign sts_o.den_zero = (acc_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

  `WLF_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, cmd_i.out_load, (!out_valid_q || !out_stall_i))
  `WLF_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, cmd_i.div_step, (den_mag_q != '0))
  `WLF_ASSERT_IMPL(a_no_write_singular, clk_i, rst_ni, cmd_i.div_write, !sing_q)

endmodule

>>> design/weighted_line_fit_accumulator_core.sv
// Weighted least-squares line fit accumulator, top level (wlf_ctrl, wlf_dp, wlf_pkg).
// Add-hit steps HIT_MUL1, HIT_MUL2, HIT_ACC; residual RES_MUL, RES_SUB, OUT (loads result).
// Solve runs the bit-serial divider (136 + 152 steps) and 24 passes
// of the shared 32x32 product unit; a singular solve ends after the determinant.
// One item in flight; next item taken while a result waits in the output register.
// Async active-low reset clears sums, line, reference z and handshake state.
module weighted_line_fit_accumulator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // reference z register
  input  logic               cfg_we_i,
  input  logic signed [23:0] cfg_wdata_i,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wlf_pkg::in_item_t  in_item_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wlf_pkg::out_item_t out_item_o
);
  import wlf_pkg::*;

  // Controller sequences each opcode; the datapath holds every data register:
  //  - hits: two product stages (w*z, w*c, z*z, c*z, then *w) and a
  //    saturating add into the five sums; opcode 0 adds onto zero.
  //  - solve: sum magnitudes are latched, then the determinant and the two
  //    Cramer numerators are built from signed 64x64 products, four 32x32
  //    partial products each, into a 129-bit accumulator. A zero
  //    determinant flags singular and leaves the line alone.
  //  - each numerator is divided by a restoring divider, one quotient bit
  //    per cycle with running saturation, truncated toward zero.
  //  - residual: z*slope product, then a clamped subtract.
  dp_cmd_t cmd;
  dp_sts_t sts;

  wlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_item_i.opcode),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wlf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
